/* rtl/msw_pkg.sv */
// Shared constants, types and the quarter-wave sine table for the waveform generator.
package msw_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int SINE_TABLE_BITS = 10;
   localparam int QTR_LEN         = 1 << SINE_TABLE_BITS;
   localparam int ROM_DEPTH       = QTR_LEN + 1;
   localparam int ROM_ADDR_W      = SINE_TABLE_BITS + 1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TAYLOR_DIV [12] = '{
      64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156,
      64'sd210, 64'sd272, 64'sd342, 64'sd420, 64'sd506, 64'sd600
   };

   typedef enum logic [2:0] {
      SHAPE_SINE     = 3'd0,
      SHAPE_COSINE   = 3'd1,
      SHAPE_SAW      = 3'd2,
      SHAPE_TRIANGLE = 3'd3,
      SHAPE_SQUARE   = 3'd4
   } shape_type;

   typedef enum logic [2:0] {
      CSR_SHAPE        = 3'd0,
      CSR_PHASE_STEP   = 3'd1,
      CSR_PHASE_OFFSET = 3'd2,
      CSR_DUTY         = 3'd3,
      CSR_AMPLITUDE    = 3'd4,
      CSR_DC_LEVEL     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [2:0]         shape;
      logic [31:0]        phase_step;
      logic [31:0]        phase_offset;
      logic [15:0]        duty;
      logic [14:0]        amplitude;
      logic signed [15:0] dc_level;
   } msw_cfg_type;

   // one queued transaction: waveform phase and the shape it was classified under
   typedef struct packed {
      logic [31:0] phase;
      logic [2:0]  shape;
   } msw_item_type;

   typedef logic [16:0] rom_word_type;
   typedef rom_word_type rom_array_type [ROM_DEPTH];

   // Q30 Taylor series of sin over a quarter wave, scaled to Q16 and clamped
   function automatic rom_array_type msw_build_rom();
      rom_array_type rom;
      longint x;
      longint x2;
      longint sum;
      longint term;
      longint v;
      int     k;
      int     n;
      for (k = 0; k < ROM_DEPTH; k++) begin
         x    = (HALF_PI_Q30 * longint'(k)) / QTR_LEN;
         x2   = (x * x) / ONE_Q30;
         sum  = x;
         term = x;
         for (n = 1; n <= 12; n++) begin
            term = (term * x2) / ONE_Q30;
            term = -term / TAYLOR_DIV[n-1];
            sum  = sum + term;
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = (sum + 64'sd8192) / 64'sd16384;
         if (v > 64'sd65536) begin
            v = 64'sd65536;
         end
         rom[k] = v[16:0];
      end
      return rom;
   endfunction

endpackage

/* rtl/msw_front.sv */
// Front end: takes request transactions, runs the phase accumulator, forms the waveform phase.
module msw_front import msw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  msw_cfg_type  cfg,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_restart,
   input  logic         queue_full,
   output logic         queue_push,
   output msw_item_type queue_item
);

   logic [PHASE_BITS-1:0] acc_ff;
   logic [PHASE_BITS-1:0] acc_in;
   logic [PHASE_BITS-1:0] acc_used;
   logic [PHASE_BITS-1:0] step_aligned;
   logic [31:0]           phase_now;
   logic                  accept;

   assign acc_used = req_restart ? '0 : acc_ff;

   // line the accumulator and the step up with a 32-bit cycle fraction
   if (PHASE_BITS > 32) begin : g_wide
      assign phase_now    = acc_used[PHASE_BITS-1 -: 32];
      assign step_aligned = {cfg.phase_step, {(PHASE_BITS-32){1'b0}}};
   end else if (PHASE_BITS == 32) begin : g_exact
      assign phase_now    = acc_used;
      assign step_aligned = cfg.phase_step;
   end else begin : g_narrow
      assign phase_now    = {acc_used, {(32-PHASE_BITS){1'b0}}};
      assign step_aligned = cfg.phase_step[31 -: PHASE_BITS];
   end

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign queue_push = accept;

   always_comb begin
      queue_item.phase = phase_now + cfg.phase_offset;
      queue_item.shape = cfg.shape;
      acc_in           = accept ? (acc_used + step_aligned) : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

/* rtl/msw_fifo.sv */
// Short register queue between the front end and the sample pipeline.
module msw_fifo import msw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  msw_item_type push_item,
   output logic         full,
   input  logic         pop,
   output msw_item_type pop_item,
   output logic         empty
);

   msw_item_type          mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_in;
   logic [FIFO_CNT_W-1:0] cnt_ff;
   logic [FIFO_CNT_W-1:0] cnt_in;

   assign full     = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* rtl/msw_back.sv */
// Sample pipeline: shape lookup, amplitude scaling, dc offset and saturation.
module msw_back import msw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  msw_cfg_type        cfg,
   input  logic               queue_empty,
   input  msw_item_type       queue_item,
   output logic               queue_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_clipped
);

   localparam rom_array_type SineRom = msw_build_rom();

   logic                         adv;
   logic [31:0]                  ph;
   logic [SINE_TABLE_BITS-1:0]   idx;
   logic [ROM_ADDR_W-1:0]        rom_addr;
   logic [17:0]                  tri_u;
   logic                         use_rom;
   logic signed [17:0]           s_direct;

   // stage 1: table data and direct shapes
   logic                         s1_valid_ff;
   logic                         s1_use_rom_ff;
   logic                         s1_neg_ff;
   logic signed [17:0]           s1_s_ff;
   rom_word_type                 rom_q_ff;

   // stage 2: product
   logic signed [17:0]           rom_signed;
   logic signed [17:0]           s2_s;
   logic signed [33:0]           prod_full;
   logic                         s2_valid_ff;
   logic signed [31:0]           prod_ff;

   // stage 3: output register
   logic signed [32:0]           rounded;
   logic signed [16:0]           scaled;
   logic signed [17:0]           total;
   logic signed [15:0]           sample_in;
   logic                         clipped_in;
   logic                         rsp_valid_ff;
   logic signed [15:0]           rsp_sample_ff;
   logic                         rsp_clipped_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign queue_pop = adv && !queue_empty;

   always_comb begin
      ph       = (queue_item.shape == SHAPE_COSINE) ? queue_item.phase + 32'h4000_0000
                                                    : queue_item.phase;
      idx      = ph[29 -: SINE_TABLE_BITS];
      rom_addr = ph[30] ? ROM_ADDR_W'(QTR_LEN) - {1'b0, idx} : {1'b0, idx};
      tri_u    = ph[31:14];
      use_rom  = 1'b0;
      s_direct = '0;
      case (queue_item.shape)
         SHAPE_SINE, SHAPE_COSINE: begin
            use_rom = 1'b1;
         end
         SHAPE_SAW: begin
            s_direct = $signed({1'b0, ~ph[31], ph[30:15]}) - 18'sd65536;
         end
         SHAPE_TRIANGLE: begin
            // rising edges read u as is; u - 2^18 wraps to the same 18 bits
            if (tri_u > 18'd65536 && tri_u <= 18'd196608) begin
               s_direct = $signed(18'd131072 - tri_u);
            end else begin
               s_direct = $signed(tri_u);
            end
         end
         SHAPE_SQUARE: begin
            s_direct = (ph < {cfg.duty, 16'h0000}) ? 18'sd65536 : -18'sd65536;
         end
         default: begin
            s_direct = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rom_q_ff      <= SineRom[rom_addr];
         s1_use_rom_ff <= use_rom;
         s1_neg_ff     <= ph[31];
         s1_s_ff       <= s_direct;
      end
   end

   always_comb begin
      rom_signed = $signed({1'b0, rom_q_ff});
      if (s1_use_rom_ff) begin
         s2_s = s1_neg_ff ? -rom_signed : rom_signed;
      end else begin
         s2_s = s1_s_ff;
      end
      prod_full = s2_s * $signed({1'b0, cfg.amplitude});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_full[31:0];
      end
   end

   always_comb begin
      // round half up, then floor by an arithmetic shift
      rounded    = 33'(prod_ff) + 33'sd32768;
      scaled     = rounded[32:16];
      total      = 18'(scaled) + 18'(cfg.dc_level);
      sample_in  = total[15:0];
      clipped_in = 1'b0;
      if (total > 18'sd32767) begin
         sample_in  = 16'sh7FFF;
         clipped_in = 1'b1;
      end else if (total < -18'sd32768) begin
         sample_in  = -16'sh8000;
         clipped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_sample_ff  <= sample_in;
         rsp_clipped_ff <= clipped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= queue_pop;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sample  = rsp_sample_ff;
   assign rsp_clipped = rsp_clipped_ff;

endmodule

/* rtl/multi_shape_waveform_generator.sv */
// Top level of the multi-shape waveform generator: register file, front end, queue, pipeline.
//
// Usage notes
// - Request channel (req_valid / req_stall / req_restart): each accepted transaction asks
//   for one sample. req_restart = 1 clears the phase accumulator before that sample.
// - Response channel (rsp_valid / rsp_stall / rsp_sample / rsp_clipped): one transaction
//   per request, in order. rsp_clipped flags that the dc-offset sum hit a rail.
// - Register port (csr_valid / csr_ready / csr_index / csr_wdata): csr_ready is always
//   high; indexes 0..5 are shape, phase step, phase offset, duty, amplitude, dc offset.
//   Other indexes are dropped. Write only while no transaction is in flight.
// - Path: an accepted request goes through the queue, then the table, product and output
//   registers before its response is valid. Throughput: one sample per clock while no stall
//   holds, set by the three stages (table read, one 18x16 multiply, round/offset/saturate).
// - Stalls: when rsp_stall holds against a valid response, the pipeline freezes and
//   requests collect in a four-entry queue; req_stall rises only once that queue is full.
// - Reset (synchronous): accumulator cleared, queue and pipeline emptied, registers
//   back to sine, zero step and offset, half duty, amplitude 16384, zero dc offset.
module multi_shape_waveform_generator import msw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_clipped,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   msw_cfg_type  cfg_ff;
   msw_cfg_type  cfg_in;
   logic         fifo_full;
   logic         fifo_empty;
   logic         fifo_push;
   logic         fifo_pop;
   msw_item_type push_item;
   msw_item_type pop_item;

   assign csr_ready = 1'b1;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SHAPE:        cfg_in.shape        = csr_wdata[2:0];
            CSR_PHASE_STEP:   cfg_in.phase_step   = csr_wdata;
            CSR_PHASE_OFFSET: cfg_in.phase_offset = csr_wdata;
            CSR_DUTY:         cfg_in.duty         = csr_wdata[15:0];
            CSR_AMPLITUDE:    cfg_in.amplitude    = csr_wdata[14:0];
            CSR_DC_LEVEL:     cfg_in.dc_level     = $signed(csr_wdata[15:0]);
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shape        <= SHAPE_SINE;
         cfg_ff.phase_step   <= '0;
         cfg_ff.phase_offset <= '0;
         cfg_ff.duty         <= 16'd32768;
         cfg_ff.amplitude    <= 15'd16384;
         cfg_ff.dc_level     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .queue_full  (fifo_full),
      .queue_push  (fifo_push),
      .queue_item  (push_item)
   );

   msw_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_item  (pop_item),
      .empty     (fifo_empty)
   );

   msw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (fifo_empty),
      .queue_item  (pop_item),
      .queue_pop   (fifo_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sample  (rsp_sample),
      .rsp_clipped (rsp_clipped)
   );

   // queue never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_full |-> !fifo_push)
      else $error("queue written while full");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a shape write lands in the register file
   a_shape_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == CSR_SHAPE) |=>
         (cfg_ff.shape == $past(csr_wdata[2:0])))
      else $error("shape register not updated");

   // a clipped sample sits on a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_sample == 16'sh7FFF || rsp_sample == -16'sh8000))
      else $error("clipped flag without saturated sample");

endmodule
